/* rtl/c1ks_pkg.sv */
// Shared types, codes and constants of the Crypto-1 keystream cipher unit.
`default_nettype none

package c1ks_pkg;

    localparam int KEY_W   = 48;
    localparam int NONCE_W = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;

    localparam logic [KEY_W-1:0] FB_TAPS = 48'h0E882B0AD621;

    localparam int unsigned NONCE_AR_STEPS = 64;
    localparam int unsigned NONCE_AT_STEPS = 96;

    localparam logic [CNT_W-1:0] BYTE_STEPS = 4'd8;

    // func codes of an input beat
    localparam logic [2:0] FUNC_LOAD    = 3'd0;
    localparam logic [2:0] FUNC_DECRYPT = 3'd1;
    localparam logic [2:0] FUNC_ENCRYPT = 3'd2;
    localparam logic [2:0] FUNC_PARTIAL = 3'd3;
    localparam logic [2:0] FUNC_NONCE   = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic [BYTE_W-1:0]  data_in;
        logic [BYTE_W-1:0]  feed_byte;
        logic               feedback_on;
        logic [CNT_W-1:0]   bit_count;
        logic [NONCE_W-1:0] nonce_in;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic               parity_out;
        logic [NONCE_W-1:0] nonce_64;
        logic [NONCE_W-1:0] nonce_96;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECRYPT,
        OP_ENCRYPT,
        OP_PARTIAL,
        OP_NONCE
    } t_op;

    // classified command handed from the front end to the execution side
    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  data;
        logic [BYTE_W-1:0]  feed;
        logic               fb_on;
        logic [CNT_W-1:0]   steps;
        logic               data_par;
        logic [NONCE_W-1:0] nonce;
    } t_cmd;

    // row j holds the input bits whose XOR gives output bit j
    typedef logic [NONCE_W-1:0][NONCE_W-1:0] t_nonce_mat;

    function automatic t_nonce_mat nonce_jump(input int unsigned steps);
        t_nonce_mat m;
        t_nonce_mat t;
        for (int j = 0; j < NONCE_W; j++) begin
            m[j] = NONCE_W'(1) << j;
        end
        for (int unsigned s = 0; s < steps; s++) begin
            for (int j = 0; j < NONCE_W - 1; j++) begin
                t[j] = m[j+1];
            end
            t[NONCE_W-1] = m[16] ^ m[18] ^ m[19] ^ m[21];
            m = t;
        end
        return m;
    endfunction

    localparam t_nonce_mat NONCE_MAT_64 = nonce_jump(NONCE_AR_STEPS);
    localparam t_nonce_mat NONCE_MAT_96 = nonce_jump(NONCE_AT_STEPS);

endpackage

`default_nettype wire

/* rtl/c1ks_front.sv */
// Front end: takes input beats and classifies them into commands.
`default_nettype none

module c1ks_front
    import c1ks_pkg::*;
(
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_full,
    output logic          o_stall,
    output logic          o_push,
    output t_cmd          o_cmd
);

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.data     = i_item.data_in;
        o_cmd.feed     = i_item.feed_byte;
        o_cmd.fb_on    = i_item.feedback_on;
        o_cmd.steps    = '0;
        o_cmd.data_par = ~(^i_item.data_in);
        o_cmd.nonce    = i_item.nonce_in;
        case (i_item.func)
            FUNC_LOAD: begin
                o_cmd.op = OP_LOAD;
            end
            FUNC_DECRYPT: begin
                o_cmd.op    = OP_DECRYPT;
                o_cmd.steps = BYTE_STEPS;
            end
            FUNC_ENCRYPT: begin
                o_cmd.op    = OP_ENCRYPT;
                o_cmd.steps = BYTE_STEPS;
            end
            FUNC_PARTIAL: begin
                o_cmd.op    = OP_PARTIAL;
                // saturate long counts at a full byte
                o_cmd.steps = (i_item.bit_count > BYTE_STEPS) ? BYTE_STEPS
                                                              : i_item.bit_count;
            end
            FUNC_NONCE: begin
                o_cmd.op = OP_NONCE;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/c1ks_queue.sv */
// Two-entry command queue between the front end and the execution side.
`default_nettype none

module c1ks_queue
    import c1ks_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/c1ks_back.sv */
// Execution side: cipher LFSR, keystream filter, nonce jump and result register.
`default_nettype none

module c1ks_back
    import c1ks_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [KEY_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    input  wire t_cmd             i_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_out_item             o_item
);

    logic [KEY_W-1:0] r_session_key;
    logic [KEY_W-1:0] r_lfsr;
    logic [KEY_W-1:0] n_lfsr;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic [KEY_W-1:0] s_clk;
    logic [BYTE_W-1:0] ks_bits;

    function automatic logic layer_a(input logic a, input logic b,
                                     input logic c, input logic d);
        return ((a | b) ^ (a & d)) ^ (c & ((a ^ b) | d));
    endfunction

    function automatic logic layer_b(input logic a, input logic b,
                                     input logic c, input logic d);
        return ((a & b) | c) ^ ((a ^ b) & (c | d));
    endfunction

    function automatic logic layer_c(input logic a, input logic b, input logic c,
                                     input logic d, input logic e);
        return (a | ((b | e) & (d ^ e))) ^ ((a ^ (b & d)) & ((c ^ d) | (b & e)));
    endfunction

    function automatic logic filt(input logic [KEY_W-1:0] s);
        return layer_c(layer_a(s[9],  s[11], s[13], s[15]),
                       layer_b(s[17], s[19], s[21], s[23]),
                       layer_b(s[25], s[27], s[29], s[31]),
                       layer_a(s[33], s[35], s[37], s[39]),
                       layer_b(s[41], s[43], s[45], s[47]));
    endfunction

    function automatic logic [NONCE_W-1:0] apply_mat(input t_nonce_mat m,
                                                     input logic [NONCE_W-1:0] x);
        logic [NONCE_W-1:0] y;
        for (int j = 0; j < NONCE_W; j++) begin
            y[j] = ^(x & m[j]);
        end
        return y;
    endfunction

    assign o_pop   = i_valid && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // LFSR unrolled over one byte, each step gated by the step count
    always_comb begin
        logic ks;
        logic nb;
        ks      = 1'b0;
        nb      = 1'b0;
        s_clk   = r_lfsr;
        ks_bits = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (CNT_W'(i) < i_cmd.steps) begin
                ks         = filt(s_clk);
                nb         = (^(s_clk & FB_TAPS)) ^ i_cmd.feed[i] ^ (ks & i_cmd.fb_on);
                ks_bits[i] = ks;
                s_clk      = {nb, s_clk[KEY_W-1:1]};
            end
        end
    end

    always_comb begin
        n_lfsr = r_lfsr;
        n_out  = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                n_lfsr = r_session_key;
            end
            OP_DECRYPT, OP_PARTIAL: begin
                n_lfsr         = s_clk;
                n_out.data_out = i_cmd.data ^ ks_bits;
            end
            OP_ENCRYPT: begin
                n_lfsr           = s_clk;
                n_out.data_out   = i_cmd.data ^ ks_bits;
                // next keystream bit, read without clocking
                n_out.parity_out = i_cmd.data_par ^ filt(s_clk);
            end
            OP_NONCE: begin
                n_out.nonce_64 = apply_mat(NONCE_MAT_64, i_cmd.nonce);
                n_out.nonce_96 = apply_mat(NONCE_MAT_96, i_cmd.nonce);
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_key <= '0;
            r_lfsr        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_session_key <= i_cfg_data;
            end
            if (o_pop) begin
                r_lfsr      <= n_lfsr;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/crypto1_keystream_cipher_unit.sv */
// Top level of the Crypto-1 keystream cipher unit.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------
//  input    | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  result   | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_data (session key)
//
// One beat per cycle sustained while i_out_stall is low; a taken input beat passes
// through the queue entry and then the result register before o_out_valid rises.
// The rate is set by the LFSR feedback loop, which clocks up to eight
// bits in one cycle; the nonce jumps are fixed XOR matrices.
// Reset clears the LFSR, the session key, the queue and the result valid.
// A stalled result holds in its register; the two-entry queue keeps taking
// beats until it fills, then o_in_stall rises.
`default_nettype none

module crypto1_keystream_cipher_unit
    import c1ks_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [KEY_W-1:0] i_cfg_data
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    c1ks_front u_front (
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    c1ks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    c1ks_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

/* verif/tb_crypto1_keystream_cipher_unit.sv */
// Self-checking testbench for the Crypto-1 keystream cipher unit.
`timescale 1ns / 100ps

module tb_crypto1_keystream_cipher_unit;
    import c1ks_pkg::*;

    localparam logic [2:0]         FUNC_RSVD_FIRST = 3'd5;
    localparam logic [2:0]         FUNC_RSVD_LAST  = 3'd7;
    localparam logic [NONCE_W-1:0] NONCE_TAPS      = 32'h002D_0000;
    localparam int                 PIPE_DRAIN      = 8;
    localparam int                 RANDOM_ITEMS    = 1800;
    localparam int                 PHASES          = 6;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_pattern;

    class cipher_scoreboard;
        logic [KEY_W-1:0] session_key;
        logic [KEY_W-1:0] cipher_state;
        t_out_item        pending_outputs[$];
        int               errors;
        int               checked;
        int               keys_written;
        int               func_hits[8];

        function new();
            session_key  = '0;
            cipher_state = '0;
            errors       = 0;
            checked      = 0;
            keys_written = 0;
            foreach (func_hits[i]) func_hits[i] = 0;
        endfunction

        function logic mix_a(logic a, logic b, logic c, logic d);
            return ((a | b) ^ (a & d)) ^ (c & ((a ^ b) | d));
        endfunction

        function logic mix_b(logic a, logic b, logic c, logic d);
            return ((a & b) | c) ^ ((a ^ b) & (c | d));
        endfunction

        function logic mix_c(logic a, logic b, logic c, logic d, logic e);
            return (a | ((b | e) & (d ^ e))) ^ ((a ^ (b & d)) & ((c ^ d) | (b & e)));
        endfunction

        function logic keystream_bit(logic [KEY_W-1:0] s);
            return mix_c(mix_a(s[9],  s[11], s[13], s[15]),
                         mix_b(s[17], s[19], s[21], s[23]),
                         mix_b(s[25], s[27], s[29], s[31]),
                         mix_a(s[33], s[35], s[37], s[39]),
                         mix_b(s[41], s[43], s[45], s[47]));
        endfunction

        // advance the cipher state, gather keystream LSB first
        function logic [BYTE_W-1:0] run_keystream(int unsigned steps,
                                                  logic [BYTE_W-1:0] feed, logic fb_on);
            logic [BYTE_W-1:0] ks;
            logic              k;
            logic              nb;
            ks = '0;
            for (int i = 0; i < steps; i++) begin
                k  = keystream_bit(cipher_state);
                nb = ^(cipher_state & FB_TAPS) ^ feed[i] ^ (k & fb_on);
                cipher_state = {nb, cipher_state[KEY_W-1:1]};
                ks[i] = k;
            end
            return ks;
        endfunction

        function logic [NONCE_W-1:0] nonce_successor(logic [NONCE_W-1:0] x,
                                                     int unsigned steps);
            for (int i = 0; i < steps; i++) begin
                x = {^(x & NONCE_TAPS), x[NONCE_W-1:1]};
            end
            return x;
        endfunction

        function void note_key(logic [KEY_W-1:0] k);
            session_key = k;
            keys_written++;
        endfunction

        function void note_input(t_in_item it);
            t_out_item   o;
            int unsigned n;
            o = '0;
            func_hits[it.func]++;
            case (it.func)
                FUNC_LOAD: cipher_state = session_key;
                FUNC_DECRYPT: begin
                    o.data_out = it.data_in ^ run_keystream(32'(BYTE_STEPS), it.feed_byte,
                                                            it.feedback_on);
                end
                FUNC_ENCRYPT: begin
                    o.data_out = it.data_in ^ run_keystream(32'(BYTE_STEPS), it.feed_byte,
                                                            it.feedback_on);
                    // odd parity of the plaintext, masked by the next bit without clocking
                    o.parity_out = ~(^it.data_in) ^ keystream_bit(cipher_state);
                end
                FUNC_PARTIAL: begin
                    n = (it.bit_count > BYTE_STEPS) ? 32'(BYTE_STEPS) : 32'(it.bit_count);
                    o.data_out = it.data_in ^ run_keystream(n, it.feed_byte, it.feedback_on);
                end
                FUNC_NONCE: begin
                    o.nonce_64 = nonce_successor(it.nonce_in, NONCE_AR_STEPS);
                    o.nonce_96 = nonce_successor(it.nonce_in, NONCE_AT_STEPS);
                end
                default: ;
            endcase
            pending_outputs.push_back(o);
        endfunction

        task report(string what, logic [NONCE_W-1:0] got, logic [NONCE_W-1:0] want);
            errors++;
            $display("%0t MISMATCH at result %0d: %s got %0h want %0h",
                     $time, checked, what, got, want);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_outputs.size() == 0) begin
                report("unexpected result beat", 0, 0);
                return;
            end
            want = pending_outputs.pop_front();
            checked++;
            if (got.data_out !== want.data_out)
                report("data_out", NONCE_W'(got.data_out), NONCE_W'(want.data_out));
            if (got.parity_out !== want.parity_out)
                report("parity_out", NONCE_W'(got.parity_out), NONCE_W'(want.parity_out));
            if (got.nonce_64 !== want.nonce_64)
                report("nonce_64", got.nonce_64, want.nonce_64);
            if (got.nonce_96 !== want.nonce_96)
                report("nonce_96", got.nonce_96, want.nonce_96);
        endtask

        task flag_leftovers();
            if (pending_outputs.size() != 0)
                report("results never delivered", pending_outputs.size(), 0);
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_item         in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [KEY_W-1:0] cfg_data  = '0;

    cipher_scoreboard sb;

    t_stall_pattern stall_mode = STALL_NONE;
    int             stall_left = 0;
    int unsigned    stall_tick = 0;

    crypto1_keystream_cipher_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure: switch to a randomly chosen pattern whenever stall_left runs out
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_pattern'($urandom_range(0, 3));
            stall_left <= $urandom_range(32, 400);
        end else begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= (stall_tick[2:0] >= 3'd5);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    function automatic t_in_item make_item(logic [2:0] func, logic [BYTE_W-1:0] data,
                                           logic [BYTE_W-1:0] feed, logic fb_on,
                                           logic [CNT_W-1:0] cnt, logic [NONCE_W-1:0] nonce);
        t_in_item it;
        it.func        = func;
        it.data_in     = data;
        it.feed_byte   = feed;
        it.feedback_on = fb_on;
        it.bit_count   = cnt;
        it.nonce_in    = nonce;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        it.data_in     = BYTE_W'($urandom);
        it.feed_byte   = BYTE_W'($urandom);
        it.feedback_on = 1'($urandom);
        it.nonce_in    = $urandom;
        // mostly legal counts, sometimes anything the field holds
        it.bit_count   = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(1, 8))
                                                     : CNT_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)       it.func = FUNC_LOAD;
        else if (pick < 30) it.func = FUNC_DECRYPT;
        else if (pick < 56) it.func = FUNC_ENCRYPT;
        else if (pick < 80) it.func = FUNC_PARTIAL;
        else if (pick < 95) it.func = FUNC_NONCE;
        else                it.func = 3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold off until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_key(input logic [KEY_W-1:0] k);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge clk); while (!cfg_ready);
        sb.note_key(k);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count, input bit with_gaps);
        int burst_left;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < count; i++) begin
            send_item(random_item());
            burst_left--;
            if (burst_left == 0) begin
                if (with_gaps) pause($urandom_range(1, 10));
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    initial begin
        logic [KEY_W-1:0] key;
        int               per_phase;
        sb = new();
        per_phase = RANDOM_ITEMS / PHASES;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key is zero: load gives an all-zero state
        send_item(make_item(FUNC_LOAD, '0, '0, 1'b0, '0, '0));
        send_item(make_item(FUNC_DECRYPT, 8'hFF, 8'h00, 1'b0, '0, '0));
        send_item(make_item(FUNC_DECRYPT, 8'h00, 8'hFF, 1'b1, '0, '0));

        write_key('1);
        send_item(make_item(FUNC_LOAD, '1, '1, 1'b1, '1, '1));
        send_item(make_item(FUNC_ENCRYPT, 8'hFF, 8'h00, 1'b0, '0, '0));
        send_item(make_item(FUNC_ENCRYPT, 8'h00, 8'hFF, 1'b1, '1, '1));
        // zero, small, full, and saturating counts
        send_item(make_item(FUNC_PARTIAL, 8'hFF, 8'hA5, 1'b0, 4'd0, '0));
        send_item(make_item(FUNC_PARTIAL, 8'hFF, 8'h5A, 1'b1, 4'd1, '0));
        send_item(make_item(FUNC_PARTIAL, 8'h00, 8'hFF, 1'b1, 4'd7, '0));
        send_item(make_item(FUNC_PARTIAL, 8'hFF, 8'h00, 1'b0, 4'd8, '0));
        send_item(make_item(FUNC_PARTIAL, 8'h3C, 8'hC3, 1'b1, 4'd9, '0));
        send_item(make_item(FUNC_PARTIAL, 8'hFF, 8'hFF, 1'b1, 4'd15, '1));
        send_item(make_item(FUNC_NONCE, '1, '1, 1'b1, '1, 32'h0000_0000));
        send_item(make_item(FUNC_NONCE, '0, '0, 1'b0, '0, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_NONCE, '0, '0, 1'b0, '0, 32'h8000_0001));
        // reserved codes must leave the state untouched
        for (int f = FUNC_RSVD_FIRST; f <= FUNC_RSVD_LAST; f++)
            send_item(make_item(3'(f), '1, '1, 1'b1, '1, '1));
        send_item(make_item(FUNC_DECRYPT, 8'h00, 8'h00, 1'b0, '0, '0));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       key = '0;
                1:       key = {1'b1, {(KEY_W-1){1'b0}}};
                2:       key = '1;
                default: key = KEY_W'({$urandom, $urandom});
            endcase
            write_key(key);
            send_item(make_item(FUNC_LOAD, BYTE_W'($urandom), BYTE_W'($urandom),
                                1'($urandom), CNT_W'($urandom), $urandom));
            if (p == 3) begin
                send_random(per_phase / 2, 1'b1);
                drain();
                send_random(per_phase - per_phase / 2, 1'b1);
            end else begin
                // every third phase runs back to back with no sender gaps
                send_random(per_phase, (p % 3) != 1);
            end
        end

        in_valid <= 1'b0;
        for (int w = 0; w < 20000 && sb.pending_outputs.size() != 0; w++) @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        sb.flag_leftovers();

        $display("checked %0d results: %0d loads, %0d decrypts, %0d encrypts, %0d partials",
                 sb.checked, sb.func_hits[FUNC_LOAD], sb.func_hits[FUNC_DECRYPT],
                 sb.func_hits[FUNC_ENCRYPT], sb.func_hits[FUNC_PARTIAL]);
        $display("%0d nonce jumps, %0d reserved codes, %0d keys written, %0d mismatches",
                 sb.func_hits[FUNC_NONCE],
                 sb.func_hits[5] + sb.func_hits[6] + sb.func_hits[7],
                 sb.keys_written, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_crypto1_keystream_cipher_unit: done, clean");
        end else begin
            $display("tb_crypto1_keystream_cipher_unit: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_crypto1_keystream_cipher_unit: done, errors");
        $finish;
    end

endmodule
